FILE: hw/rtl/triangle_face_normal_defines.svh
// ---------------------------------------------------------------------------
// triangle_face_normal assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication
`define TFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tfn_pkg.sv
// ---------------------------------------------------------------------------
// tfn_pkg
// Fixed constants and shared types of the face normal pipeline.
// ---------------------------------------------------------------------------
package tfn_pkg;

    // normalised magnitudes carry this many significant bits
    localparam int NORM_BITS = 30;
    // sum of three squares of NORM_BITS values
    localparam int L2_W      = 2 * NORM_BITS + 2;
    // square root result width and pipeline depth
    localparam int LEN_W     = NORM_BITS + 1;
    localparam int SQ_STAGES = LEN_W;

    typedef struct packed {
        logic en;   // pipeline advance
        logic vld;  // item present at the stage input
    } t_pipe_ctl;

endpackage

FILE: hw/rtl/tfn_sqrt.sv
// ---------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one result bit per stage, with side tag.
// ---------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; #(
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [L2_W-1:0]  i_l2,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [LEN_W-1:0] o_len,
    output logic [TAG_W-1:0] o_tag
);

    logic [L2_W-1:0]  w_v   [0:SQ_STAGES];
    logic [L2_W-1:0]  w_res [0:SQ_STAGES];
    logic [TAG_W-1:0] w_tag [0:SQ_STAGES];
    logic             w_vld [0:SQ_STAGES];

    assign w_v[0]   = i_l2;
    assign w_res[0] = '0;
    assign w_tag[0] = i_tag;
    assign w_vld[0] = i_ctl.vld;

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [L2_W-1:0] BIT = L2_W'(1) << (L2_W - 2 - 2 * k);
        logic [L2_W-1:0]  r_v, r_res, n_v, n_res, n_try;
        logic [TAG_W-1:0] r_tag;
        logic             r_vld;

        always_comb begin
            n_try = w_res[k] + BIT;
            if (w_v[k] >= n_try) begin
                n_v   = w_v[k] - n_try;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_v   = w_v[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld <= w_vld[k];
            end
            if (i_ctl.en) begin
                r_v   <= n_v;
                r_res <= n_res;
                r_tag <= w_tag[k];
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_res[k+1] = r_res;
        assign w_tag[k+1] = r_tag;
        assign w_vld[k+1] = r_vld;
    end

    assign o_vld = w_vld[SQ_STAGES];
    assign o_len = w_res[SQ_STAGES][LEN_W-1:0];
    assign o_tag = w_tag[SQ_STAGES];

endmodule

FILE: hw/rtl/tfn_div.sv
// ---------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined restoring divider with rounding, one quotient bit per
// stage, all lanes sharing one divisor.
// ---------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; #(
    parameter int UNIT_FRAC_BITS = 16,
    parameter int TAG_W          = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic [LEN_W-1:0]        i_len,
    input  logic [NORM_BITS-1:0]    i_a [0:2],
    input  logic [TAG_W-1:0]        i_tag,
    output logic                    o_vld,
    output logic [UNIT_FRAC_BITS:0] o_q [0:2],
    output logic [TAG_W-1:0]        o_tag
);

    localparam int QW = UNIT_FRAC_BITS + 1;
    localparam int DW = UNIT_FRAC_BITS + LEN_W + 1;

    logic [DW-1:0]    w_rem [0:QW][0:2];
    logic [QW-1:0]    w_q   [0:QW][0:2];
    logic [LEN_W-1:0] w_len [0:QW];
    logic [TAG_W-1:0] w_tag [0:QW];
    logic             w_vld [0:QW];
    logic [LEN_W-1:0] w_div;

    // guard the divisor: a zero length only comes with zero magnitudes
    assign w_div    = (i_len == '0) ? LEN_W'(1) : i_len;
    assign w_len[0] = w_div;
    assign w_tag[0] = i_tag;
    assign w_vld[0] = i_ctl.vld;

    for (genvar l = 0; l < 3; l++) begin : g_in
        assign w_rem[0][l] = (DW'(i_a[l]) << UNIT_FRAC_BITS) + DW'(w_div >> 1);
        assign w_q[0][l]   = '0;
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic [DW-1:0]    n_d;
        logic [DW-1:0]    r_rem [0:2];
        logic [QW-1:0]    r_q   [0:2];
        logic [LEN_W-1:0] r_len;
        logic [TAG_W-1:0] r_tag;
        logic             r_vld;

        assign n_d = DW'(w_len[j]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld <= w_vld[j];
            end
            if (i_ctl.en) begin
                r_len <= w_len[j];
                r_tag <= w_tag[j];
                for (int l = 0; l < 3; l++) begin
                    if (w_rem[j][l] >= n_d) begin
                        r_rem[l] <= w_rem[j][l] - n_d;
                        r_q[l]   <= w_q[j][l] | (QW'(1) << B);
                    end else begin
                        r_rem[l] <= w_rem[j][l];
                        r_q[l]   <= w_q[j][l];
                    end
                end
            end
        end

        assign w_len[j+1] = r_len;
        assign w_tag[j+1] = r_tag;
        assign w_vld[j+1] = r_vld;
        for (genvar l = 0; l < 3; l++) begin : g_lane
            assign w_rem[j+1][l] = r_rem[l];
            assign w_q[j+1][l]   = r_q[l];
        end
    end

    assign o_vld = w_vld[QW];
    assign o_tag = w_tag[QW];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_q[l] = w_q[QW][l];
    end

endmodule

FILE: hw/rtl/triangle_face_normal.sv
// ---------------------------------------------------------------------------
// triangle_face_normal
// Face normal of one triangle per transaction: exact cross product of the
// edges and the same vector scaled to unit length.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload
//  s_axis    in   tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
//  m_axis    out  tdata: raw_x raw_y raw_z unit_x unit_y unit_z, tuser: degenerate
//
//  One transaction enters per cycle while the output buffer has room. Results pass
//  through the local stages, the 31-stage square root and the bit-per-stage divider
//  into the output buffer, where they are registered.
//  Reset is synchronous and active low; it clears valid bits and the buffer.
//  All stages advance together while the two-entry output buffer has room,
//  so input is still taken while one result waits on m_axis.
//
`include "triangle_face_normal_defines.svh"

module triangle_face_normal import tfn_pkg::*; #(
    parameter int COORD_BITS     = 24,
    parameter int UNIT_FRAC_BITS = 16,
    localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int RAW_W = 2 * COORD_BITS + 3,
    localparam int UW    = UNIT_FRAC_BITS + 2,
    localparam int OUT_W = ((3 * RAW_W + 3 * UW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // raw_x, raw_y, raw_z, unit_x, unit_y, unit_z from bit 0 up
    output logic [OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]       m_axis_tuser
);

    localparam int EW    = COORD_BITS + 1;
    localparam int PW    = 2 * EW;
    localparam int FLD_W = 3 * RAW_W + 3 * UW;
    localparam int SQT_W = 1 + 3 * RAW_W + 3 * NORM_BITS;
    localparam int DVT_W = 1 + 3 * RAW_W;
    localparam int BL_W  = $clog2(RAW_W + 1);

    // ---- global advance: every stage moves while the buffer has room ----
    logic       w_en;
    logic [1:0] r_cnt;
    logic       r_vld [1:9];

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    // ---- stage 1: edges ----
    logic signed [COORD_BITS-1:0] w_v [0:8];
    logic signed [EW-1:0]         r_e1 [0:2];
    logic signed [EW-1:0]         r_e2 [0:2];

    for (genvar i = 0; i < 9; i++) begin : g_coord
        assign w_v[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'(w_v[3+k]) - EW'(w_v[k]);
                r_e2[k] <= EW'(w_v[6+k]) - EW'(w_v[k]);
            end
        end
    end

    // ---- stage 2: six partial products ----
    logic signed [PW-1:0] r_p [0:5];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
        end
    end

    // ---- stage 3: raw normal ----
    logic signed [RAW_W-1:0] r_raw3 [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_raw3[k] <= RAW_W'(r_p[2*k]) - RAW_W'(r_p[2*k+1]);
            end
        end
    end

    // ---- stage 4: magnitudes ----
    logic signed [RAW_W-1:0] r_raw4 [0:2];
    logic [RAW_W-1:0]        r_mag4 [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_raw4[k] <= r_raw3[k];
                r_mag4[k] <= r_raw3[k][RAW_W-1] ? RAW_W'(-r_raw3[k]) : RAW_W'(r_raw3[k]);
            end
        end
    end

    // ---- stage 5: largest magnitude ----
    logic signed [RAW_W-1:0] r_raw5 [0:2];
    logic [RAW_W-1:0]        r_mag5 [0:2];
    logic [RAW_W-1:0]        r_mx5;
    logic [RAW_W-1:0]        n_mx;

    always_comb begin
        n_mx = r_mag4[0];
        if (r_mag4[1] > n_mx) n_mx = r_mag4[1];
        if (r_mag4[2] > n_mx) n_mx = r_mag4[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw5 <= r_raw4;
            r_mag5 <= r_mag4;
            r_mx5  <= n_mx;
        end
    end

    // ---- stage 6: bit length of the largest magnitude ----
    logic signed [RAW_W-1:0] r_raw6 [0:2];
    logic [RAW_W-1:0]        r_mag6 [0:2];
    logic [BL_W-1:0]         r_bl6;
    logic                    r_dg6;
    logic [BL_W-1:0]         n_bl;

    always_comb begin
        n_bl = '0;
        for (int b = 0; b < RAW_W; b++) begin
            if (r_mx5[b]) n_bl = BL_W'(b + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw6 <= r_raw5;
            r_mag6 <= r_mag5;
            r_bl6  <= n_bl;
            r_dg6  <= (r_mx5 == '0);
        end
    end

    // ---- stage 7: normalise so the largest has NORM_BITS bits ----
    // (m << NORM_BITS) >> bl covers both the exact left shift and the
    // truncating right shift.
    logic signed [RAW_W-1:0] r_raw7 [0:2];
    logic [NORM_BITS-1:0]    r_a7 [0:2];
    logic                    r_dg7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw7 <= r_raw6;
            r_dg7  <= r_dg6;
            for (int k = 0; k < 3; k++) begin
                r_a7[k] <= NORM_BITS'(({r_mag6[k], {NORM_BITS{1'b0}}}) >> r_bl6);
            end
        end
    end

    // ---- stage 8: squares ----
    logic signed [RAW_W-1:0]  r_raw8 [0:2];
    logic [NORM_BITS-1:0]     r_a8 [0:2];
    logic [2*NORM_BITS-1:0]   r_sq8 [0:2];
    logic                     r_dg8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw8 <= r_raw7;
            r_a8   <= r_a7;
            r_dg8  <= r_dg7;
            for (int k = 0; k < 3; k++) begin
                r_sq8[k] <= r_a7[k] * r_a7[k];
            end
        end
    end

    // ---- stage 9: squared length ----
    logic signed [RAW_W-1:0] r_raw9 [0:2];
    logic [NORM_BITS-1:0]    r_a9 [0:2];
    logic [L2_W-1:0]         r_l2;
    logic                    r_dg9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raw9 <= r_raw8;
            r_a9   <= r_a8;
            r_dg9  <= r_dg8;
            r_l2   <= L2_W'(r_sq8[0]) + L2_W'(r_sq8[1]) + L2_W'(r_sq8[2]);
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 9; s++) r_vld[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= s_axis_tvalid;
            for (int s = 2; s <= 9; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // ---- square root ----
    t_pipe_ctl        w_sq_ctl;
    logic [SQT_W-1:0] w_sq_tag_in, w_sq_tag_out;
    logic             w_sq_vld;
    logic [LEN_W-1:0] w_len;

    assign w_sq_ctl    = '{en: w_en, vld: r_vld[9]};
    assign w_sq_tag_in = {r_dg9, r_raw9[2], r_raw9[1], r_raw9[0], r_a9[2], r_a9[1], r_a9[0]};

    tfn_sqrt #(
        .TAG_W (SQT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_l2    (r_l2),
        .i_tag   (w_sq_tag_in),
        .o_vld   (w_sq_vld),
        .o_len   (w_len),
        .o_tag   (w_sq_tag_out)
    );

    // ---- division ----
    t_pipe_ctl               w_dv_ctl;
    logic [NORM_BITS-1:0]    w_dv_a [0:2];
    logic [DVT_W-1:0]        w_dv_tag_in, w_dv_tag_out;
    logic                    w_dv_vld;
    logic [UNIT_FRAC_BITS:0] w_q [0:2];

    assign w_dv_ctl    = '{en: w_en, vld: w_sq_vld};
    assign w_dv_tag_in = w_sq_tag_out[SQT_W-1 -: DVT_W];
    for (genvar k = 0; k < 3; k++) begin : g_dva
        assign w_dv_a[k] = w_sq_tag_out[k*NORM_BITS +: NORM_BITS];
    end

    tfn_div #(
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
        .TAG_W          (DVT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dv_ctl),
        .i_len   (w_len),
        .i_a     (w_dv_a),
        .i_tag   (w_dv_tag_in),
        .o_vld   (w_dv_vld),
        .o_q     (w_q),
        .o_tag   (w_dv_tag_out)
    );

    // ---- sign, degenerate override, result packing ----
    logic          w_dg;
    logic [UW-1:0] w_unit [0:2];
    logic [FLD_W:0] w_res;

    assign w_dg = w_dv_tag_out[DVT_W-1];
    for (genvar k = 0; k < 3; k++) begin : g_unit
        logic w_neg;
        assign w_neg     = w_dv_tag_out[k*RAW_W + RAW_W - 1];
        assign w_unit[k] = w_dg ? '0 :
                           (w_neg ? UW'(-UW'(w_q[k])) : UW'(w_q[k]));
    end

    assign w_res = {w_dg, w_unit[2], w_unit[1], w_unit[0],
                    w_dv_tag_out[3*RAW_W-1:0]};

    // ---- two-entry output buffer ----
    logic [FLD_W:0] r_buf [0:1];
    logic           w_push, w_pop;
    logic [1:0]     n_cnt, n_wi;

    assign w_push = w_en && w_dv_vld;
    assign w_pop  = (r_cnt != 2'd0) && m_axis_tready;
    assign n_cnt  = r_cnt + 2'(w_push) - 2'(w_pop);
    assign n_wi   = r_cnt - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        // advance the queue; a new result lands behind what stays
        if (w_push && (n_wi == 2'd0)) begin
            r_buf[0] <= w_res;
        end else if (w_pop) begin
            r_buf[0] <= r_buf[1];
        end
        if (w_push && (n_wi == 2'd1)) begin
            r_buf[1] <= w_res;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = OUT_W'(r_buf[0][FLD_W-1:0]);
    assign m_axis_tuser  = r_buf[0][FLD_W];

    // ---- checks ----
    `TFN_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt != 2'd3, "output buffer count out of range")
    `TFN_ASSERT_NOW(a_no_overfill, w_push, r_cnt != 2'd2, "result pushed into a full buffer")
    `TFN_ASSERT_NEXT(a_full_hold, (r_cnt == 2'd2) && !m_axis_tready, r_cnt == 2'd2,
        "full buffer changed without a pop")
    `TFN_ASSERT_NEXT(a_accept_stage, s_axis_tvalid && s_axis_tready, r_vld[1],
        "accepted transaction missing from first stage")
    `TFN_ASSERT_NOW(a_degen_zero, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[3*RAW_W +: 3*UW] == '0, "degenerate result with nonzero unit vector")

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_face_normal: a directed table of faces,
// then random faces under three idling phases and one long output hold-off,
// every result compared field by field with a local face-normal predictor.
// ---------------------------------------------------------------------------
module tb;

    localparam int CB    = 24;
    localparam int UF    = 16;
    localparam int NB    = 30;
    localparam int IN_W  = ((9 * CB + 7) / 8) * 8;
    localparam int RAW_W = 2 * CB + 3;
    localparam int UW    = UF + 2;
    localparam int OUT_W = ((3 * RAW_W + 3 * UW + 7) / 8) * 8;
    localparam int LATENCY = 58;
    localparam int N_RANDOM = 1380;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_z;
        logic [UW-1:0]    unit_x;
        logic [UW-1:0]    unit_y;
        logic [UW-1:0]    unit_z;
        logic             degenerate;
    } t_normal;

    typedef struct {
        logic [CB-1:0] v[9];
        logic          has_exp;     // expected fields typed in below
        t_normal       exp_n;
    } t_face_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // raw_x, raw_y, raw_z, unit_x, unit_y, unit_z from bit 0 up
    logic [OUT_W-1:0] m_axis_tdata;
    // degenerate
    logic [0:0]       m_axis_tuser;

    t_normal   normal_q[$];
    t_face_row face_rows[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_off = 1'b0;
    logic      sending_done = 1'b0;
    logic      burst_phase = 1'b0;
    longint    cycles = 0;

    triangle_face_normal #(.COORD_BITS(CB), .UNIT_FRAC_BITS(UF)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    // cycle ceiling: end the run if the block stops making progress
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // exact cross product of the edges, then unit scaling with rounded division
    function automatic t_normal face_normal(logic [CB-1:0] v[9]);
        t_normal     r;
        longint      p[9];
        longint      e1[3];
        longint      e2[3];
        longint      n[3];
        logic [63:0] a[3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] q;
        int          bl;
        for (int i = 0; i < 9; i++) p[i] = longint'($signed(v[i]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3 + i] - p[i];
            e2[i] = p[6 + i] - p[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r.raw_x = n[0][RAW_W-1:0];
        r.raw_y = n[1][RAW_W-1:0];
        r.raw_z = n[2][RAW_W-1:0];
        for (int i = 0; i < 3; i++) a[i] = (n[i] < 0) ? -n[i] : n[i];
        mx = a[0];
        if (a[1] > mx) mx = a[1];
        if (a[2] > mx) mx = a[2];
        r.unit_x = '0;
        r.unit_y = '0;
        r.unit_z = '0;
        r.degenerate = (mx == 0);
        if (mx == 0) return r;
        bl = 0;
        while (mx != 0) begin
            bl++;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++) begin
            if (bl > NB) a[i] = a[i] >> (bl - NB);
            else a[i] = a[i] << (NB - bl);
        end
        len = isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << UF) + (len >> 1)) / len;
            if (n[i] < 0) q = -q;
            case (i)
                0: r.unit_x = q[UW-1:0];
                1: r.unit_y = q[UW-1:0];
                default: r.unit_z = q[UW-1:0];
            endcase
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_face(logic [CB-1:0] v[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*CB +: CB] = v[i];
        return d;
    endfunction

    // hold the face until the block takes it, idling first at random
    task automatic send_face(logic [CB-1:0] v[9]);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_face(v);
        normal_q.insert(normal_q.size(), face_normal(v));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic add_row(logic [CB-1:0] v[9], logic has_exp = 1'b0,
                           t_normal exp_n = '0);
        t_face_row row;
        row.v = v;
        row.has_exp = has_exp;
        row.exp_n = exp_n;
        face_rows.insert(face_rows.size(), row);
    endtask

    // receiver: stall at random, or hold off entirely while hold_off is set
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transaction with the oldest expected normal
    always @(posedge i_clk) begin
        t_normal got;
        t_normal want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.raw_x      = m_axis_tdata[0 +: RAW_W];
            got.raw_y      = m_axis_tdata[RAW_W +: RAW_W];
            got.raw_z      = m_axis_tdata[2*RAW_W +: RAW_W];
            got.unit_x     = m_axis_tdata[3*RAW_W +: UW];
            got.unit_y     = m_axis_tdata[3*RAW_W + UW +: UW];
            got.unit_z     = m_axis_tdata[3*RAW_W + 2*UW +: UW];
            got.degenerate = m_axis_tuser[0];
            if (normal_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (got.raw_x !== want.raw_x) begin
                    $error("raw_x exp %h got %h", want.raw_x, got.raw_x); errors++;
                end
                if (got.raw_y !== want.raw_y) begin
                    $error("raw_y exp %h got %h", want.raw_y, got.raw_y); errors++;
                end
                if (got.raw_z !== want.raw_z) begin
                    $error("raw_z exp %h got %h", want.raw_z, got.raw_z); errors++;
                end
                if (got.unit_x !== want.unit_x) begin
                    $error("unit_x exp %h got %h", want.unit_x, got.unit_x); errors++;
                end
                if (got.unit_y !== want.unit_y) begin
                    $error("unit_y exp %h got %h", want.unit_y, got.unit_y); errors++;
                end
                if (got.unit_z !== want.unit_z) begin
                    $error("unit_z exp %h got %h", want.unit_z, got.unit_z); errors++;
                end
                if (got.degenerate !== want.degenerate) begin
                    $error("degenerate exp %b got %b", want.degenerate, got.degenerate);
                    errors++;
                end
            end
        end
    end

    // long output hold-off early in the no-idle phase: the pipeline fills and
    // stalls input while the sender keeps offering
    initial begin
        wait (burst_phase && !sending_done);
        repeat (50) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        logic [CB-1:0] v[9];
        logic [CB-1:0] mx;
        logic [CB-1:0] mn;
        t_normal       e;
        int            k;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};

        // all zero: degenerate, zero unit vector
        v = '{default: '0};
        e = '0;
        e.degenerate = 1'b1;
        add_row(v, 1'b1, e);
        // collinear vertices: degenerate
        v = '{0, 0, 0, 24'h1000, 24'h1000, 24'h1000, 24'h2000, 24'h2000, 24'h2000};
        add_row(v, 1'b1, e);
        // unit right triangle in the xy plane: normal +z
        v = '{0, 0, 0, 24'h1000, 0, 0, 0, 24'h1000, 0};
        e = '0;
        e.raw_z  = 51'h1000000;
        e.unit_z = 18'h10000;
        add_row(v, 1'b1, e);
        // reversed winding: normal -z
        v = '{0, 0, 0, 0, 24'h1000, 0, 24'h1000, 0, 0};
        e.raw_z  = -51'sh1000000;
        e.unit_z = -18'sh10000;
        add_row(v, 1'b1, e);
        // extremes of the coordinate range
        v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; add_row(v);
        v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; add_row(v);
        v = '{mn, mn, mn, mx, mx, mn, mn, mx, mx}; add_row(v);
        v = '{mx, mn, mx, mn, mx, mn, mx, mx, mn}; add_row(v);
        v = '{mn, mx, mn, mx, mn, mn, mn, mn, mx}; add_row(v);
        // smallest non-zero normal, and a single-lsb skew
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; add_row(v);
        v = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; add_row(v);
        v = '{'1, '1, '1, 0, '1, '1, '1, 0, '1}; add_row(v);
        // all-ones pattern and alternating patterns
        v = '{default: '1}; add_row(v);
        v = '{24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
              24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555}; add_row(v);
        v = '{24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
              24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa}; add_row(v);
        // equal components: normal along the diagonal
        v = '{24'h1000, 0, 0, 0, 24'h1000, 0, 0, 0, 24'h1000}; add_row(v);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (face_rows[r]) begin
            // a typed-in row must agree with the predictor as well
            if (face_rows[r].has_exp && face_normal(face_rows[r].v) !== face_rows[r].exp_n) begin
                $error("table row %0d disagrees with predictor", r);
                errors++;
            end
            send_face(face_rows[r].v);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
            if (ph == 2) burst_phase = 1'b1;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                k = $urandom_range(9);
                for (int i = 0; i < 9; i++) v[i] = $urandom();
                if (k == 0) begin
                    // degenerate: third vertex copies one of the others
                    for (int i = 0; i < 3; i++) v[6 + i] = v[i];
                end else if (k < 4) begin
                    // small triangles near the origin: modest normal lengths
                    for (int i = 0; i < 9; i++) v[i] = $signed(12'($urandom()));
                end else if (k == 4) begin
                    // coordinates pinned to the extremes
                    for (int i = 0; i < 9; i++) v[i] = $urandom_range(1) ? mx : mn;
                end
                send_face(v);
            end
        end
        s_axis_tvalid <= 1'b0;
        sending_done <= 1'b1;

        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_sqrt.sv
hw/rtl/tfn_div.sv
hw/rtl/triangle_face_normal.sv
test/tb.sv
